### rtl/core/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// Shared constants, types and the generation rule for the life grid.
// ----------------------------------------------------------------------------
package lag_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int CNT_W     = $clog2(GRID_ROWS + 2);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } lag_op_t;

    typedef logic [GRID_COLS-1:0] lag_row_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
    } lag_rd_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
        lag_row_t         data;
    } lag_wr_t;

    // B3/S23 on one row, given the old rows above and below
    function automatic lag_row_t lag_next_row(lag_row_t above, lag_row_t mid, lag_row_t below);
        lag_row_t    res;
        lag_row_t    a_l;
        lag_row_t    a_r;
        lag_row_t    m_l;
        lag_row_t    m_r;
        lag_row_t    b_l;
        lag_row_t    b_r;
        logic [3:0]  n;
        a_l = above << 1;
        a_r = above >> 1;
        m_l = mid << 1;
        m_r = mid >> 1;
        b_l = below << 1;
        b_r = below >> 1;
        for (int c = 0; c < GRID_COLS; c++) begin
            n = 4'(a_l[c]) + 4'(above[c]) + 4'(a_r[c]) + 4'(m_l[c]) + 4'(m_r[c])
              + 4'(b_l[c]) + 4'(below[c]) + 4'(b_r[c]);
            res[c] = (n == 4'd3) || ((n == 4'd2) && mid[c]);
        end
        return res;
    endfunction

endpackage

### rtl/core/lag_row_store.sv
// ----------------------------------------------------------------------------
// lag_row_store
// Row memory of the grid with per-row valid flags; unwritten rows read dead.
// ----------------------------------------------------------------------------
module lag_row_store (
    input  logic              aclk,
    input  logic              aresetn,
    input  lag_pkg::lag_rd_t  rd,
    input  lag_pkg::lag_wr_t  wr,
    output lag_pkg::lag_row_t rd_row
);

    lag_pkg::lag_row_t              mem [lag_pkg::GRID_ROWS];
    logic [lag_pkg::GRID_ROWS-1:0]  row_valid_reg;
    lag_pkg::lag_row_t              rd_data_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                row_valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_valid_reg <= row_valid_reg[rd.addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/core/life_automaton_grid.sv
// ----------------------------------------------------------------------------
// life_automaton_grid
// Cell grid under rule B3/S23 with cell write, cell read and generation step.
// ----------------------------------------------------------------------------
// A write or ignored item passes through the write state back to idle; a read
// result is registered in the read state, which waits while the output stalls.
// A step sweeps the rows in order; the row memory gives one row read and one
// row write per cycle. One item is in work at a time. Reset clears the row
// valid flags, so the whole grid reads dead at once; no clearing sweep is run.
// ----------------------------------------------------------------------------
module life_automaton_grid (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [5:0] s_row,
    input  logic [5:0] s_col,
    input  logic       s_alive,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_cell_alive
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_STEP
    } state_t;

    state_t                      state_reg, state_next;
    logic [lag_pkg::ROW_W-1:0]   req_row_reg, req_row_next;
    logic [lag_pkg::COL_W-1:0]   req_col_reg, req_col_next;
    logic                        req_alive_reg, req_alive_next;
    logic                        req_inside_reg, req_inside_next;
    logic [lag_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    lag_pkg::lag_row_t           prev_reg, prev_next;
    lag_pkg::lag_row_t           cur_reg, cur_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        m_cell_reg, m_cell_next;

    lag_pkg::lag_rd_t            rd;
    lag_pkg::lag_wr_t            wr;
    lag_pkg::lag_row_t           rd_row;
    lag_pkg::lag_row_t           below_row;
    lag_pkg::lag_row_t           mod_row;
    lag_pkg::lag_op_t            op;
    logic                        in_grid;
    logic                        accept;
    logic                        step_last;

    lag_row_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rd),
        .wr      (wr),
        .rd_row  (rd_row)
    );

    assign op        = lag_pkg::lag_op_t'(s_opcode);
    assign in_grid   = (32'(s_row) < lag_pkg::GRID_ROWS) && (32'(s_col) < lag_pkg::GRID_COLS);
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign step_last = (32'(cnt_reg) == lag_pkg::GRID_ROWS + 1);
    assign below_row = (32'(cnt_reg) > lag_pkg::GRID_ROWS) ? '0 : rd_row;

    always_comb begin
        mod_row              = rd_row;
        mod_row[req_col_reg] = req_alive_reg;
    end

    always_comb begin
        rd.en   = 1'b0;
        rd.addr = lag_pkg::ROW_W'(s_row);
        wr.en   = 1'b0;
        wr.addr = req_row_reg;
        wr.data = mod_row;
        unique case (state_reg)
            ST_IDLE: begin
                rd.en = accept && in_grid
                     && ((op == lag_pkg::OP_WRITE) || (op == lag_pkg::OP_READ));
            end
            ST_WRITE: begin
                wr.en = req_inside_reg;
            end
            ST_STEP: begin
                rd.en   = (32'(cnt_reg) < lag_pkg::GRID_ROWS);
                rd.addr = cnt_reg[lag_pkg::ROW_W-1:0];
                wr.en   = (cnt_reg >= lag_pkg::CNT_W'(2));
                wr.addr = lag_pkg::ROW_W'(cnt_reg - lag_pkg::CNT_W'(2));
                wr.data = lag_pkg::lag_next_row(prev_reg, cur_reg, below_row);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        req_row_next    = req_row_reg;
        req_col_next    = req_col_reg;
        req_alive_next  = req_alive_reg;
        req_inside_next = req_inside_reg;
        cnt_next        = cnt_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cell_next     = m_cell_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_row_next    = lag_pkg::ROW_W'(s_row);
                    req_col_next    = lag_pkg::COL_W'(s_col);
                    req_alive_next  = s_alive;
                    req_inside_next = in_grid;
                    cnt_next        = '0;
                    prev_next       = '0;
                    cur_next        = '0;
                    case (op)
                        lag_pkg::OP_STEP: state_next = ST_STEP;
                        lag_pkg::OP_READ: state_next = ST_READ;
                        lag_pkg::OP_WRITE: state_next = ST_WRITE;
                        default: begin
                            req_inside_next = 1'b0;
                            state_next      = ST_WRITE;
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            ST_READ: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_cell_next  = req_inside_reg && rd_row[req_col_reg];
                    state_next   = ST_IDLE;
                end
            end
            ST_STEP: begin
                cnt_next = cnt_reg + lag_pkg::CNT_W'(1);
                if (cnt_reg != '0) begin
                    prev_next = cur_reg;
                    cur_next  = below_row;
                end
                if (step_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        req_row_reg    <= req_row_next;
        req_col_reg    <= req_col_next;
        req_alive_reg  <= req_alive_next;
        req_inside_reg <= req_inside_next;
        cnt_reg        <= cnt_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        m_cell_reg     <= m_cell_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_alive = m_cell_reg;

endmodule

### rtl/core/lag_checker.sv
// ----------------------------------------------------------------------------
// lag_checker
// Port-level checks on the life grid, bound to the top level.
// ----------------------------------------------------------------------------
module lag_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_opcode,
    input logic [5:0] s_row,
    input logic [5:0] s_col,
    input logic       s_alive,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_cell_alive
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_alive))
        else $error("result changed while stalled");

    // drop ready for the cycle after any transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transfer taken while busy");

    // deliver a read result that was taken while no result was pending
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == lag_pkg::OP_READ) && !m_valid
        |-> ##2 m_valid)
        else $error("read result missing");

    // keep ready low at the end of the generation sweep
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == lag_pkg::OP_STEP)
        |-> ##(lag_pkg::GRID_ROWS + 2) !s_ready)
        else $error("input taken during generation step");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind life_automaton_grid lag_checker u_lag_checker (.*);
